[design/mufind_pkg.sv]
// mufind_pkg: shared types and constants for the mode and unique finder
// request and response payload structs, controller command/status structs and
// the state encoding. no dependencies
package mufind_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned OCC_W   = 6;

   localparam logic KIND_UNIQUE = 1'b0;
   localparam logic KIND_MODE   = 1'b1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] reported_value;
      logic [OCC_W-1:0]          occurrences;
      logic                      overflow;
      logic                      last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic fetch;
      logic sweep;
      logic decide;
      logic mode;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic j_last;
      logic i_last;
      logic eq_one;
      logic slot_free;
   } status_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_SWEEP,
      ST_DRAIN,
      ST_DECIDE,
      ST_MODE
   } state_type;

endpackage

[design/mufind_ram.sv]
// mufind_ram: generic single-port-write, single-port-read ram
// read data is registered. no dependencies
module mufind_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mufind_ctrl.sv]
// mufind_ctrl: sequencing state machine for the mode and unique finder
// drives the datapath commands from its status; uses mufind_pkg
module mufind_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  mufind_pkg::status_type status,
   output mufind_pkg::cmd_type    cmd
);

   mufind_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mufind_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mufind_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = mufind_pkg::ST_FETCH;
               end
            end
         end
         mufind_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = mufind_pkg::ST_SWEEP;
         end
         mufind_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.j_last) begin
               state_in = mufind_pkg::ST_DRAIN;
            end
         end
         mufind_pkg::ST_DRAIN: begin
            // last compare lands this cycle
            state_in = mufind_pkg::ST_DECIDE;
         end
         mufind_pkg::ST_DECIDE: begin
            // a unique report needs a free output slot
            if (!status.eq_one || status.slot_free) begin
               cmd.decide = 1'b1;
               state_in   = status.i_last ? mufind_pkg::ST_MODE : mufind_pkg::ST_FETCH;
            end
         end
         mufind_pkg::ST_MODE: begin
            if (status.slot_free) begin
               cmd.mode = 1'b1;
               state_in = mufind_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mufind_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

[design/mufind_dp.sv]
// mufind_dp: value store, pairwise count, best tracking and response register
// uses mufind_pkg and mufind_ram
module mufind_dp #(
   parameter int unsigned MAX_ITEMS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mufind_pkg::req_type    req_data,
   input  mufind_pkg::cmd_type    cmd,
   output mufind_pkg::status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mufind_pkg::rsp_type    rsp_data
);

   localparam int unsigned IW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
   localparam int unsigned VW = mufind_pkg::VALUE_W;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] eq_cnt_ff, eq_cnt_in;
   logic [VW-1:0] outer_ff, outer_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [CW-1:0] best_cnt_ff, best_cnt_in;
   logic [VW-1:0] best_val_ff, best_val_in;
   logic          lat_ff, cmp_vld_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   mufind_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [IW-1:0] rd_addr;
   logic [VW-1:0] rd_data;
   logic          not_full;
   logic [CW-1:0] last_idx;

   assign not_full = (cnt_ff < CW'(MAX_ITEMS));
   assign wr_en    = cmd.load && not_full;
   assign rd_addr  = cmd.fetch ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign last_idx = cnt_ff - CW'(1);

   mufind_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data (req_data.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.j_last    = (j_ff == last_idx);
   assign status.i_last    = (i_ff == last_idx);
   assign status.eq_one    = (eq_cnt_ff == CW'(1));
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      eq_cnt_in    = eq_cnt_ff;
      outer_in     = outer_ff;
      best_idx_in  = best_idx_ff;
      best_cnt_in  = best_cnt_ff;
      best_val_in  = best_val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         if (not_full) begin
            cnt_in = cnt_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.fetch) begin
         j_in      = '0;
         eq_cnt_in = '0;
      end
      if (cmd.sweep) begin
         j_in = j_ff + CW'(1);
      end
      // outer value arrives in the cycle after its read
      if (lat_ff) begin
         outer_in = rd_data;
      end
      if (cmp_vld_ff && (rd_data == outer_ff)) begin
         eq_cnt_in = eq_cnt_ff + CW'(1);
      end

      if (cmd.decide) begin
         if (eq_cnt_ff > best_cnt_ff) begin
            best_cnt_in = eq_cnt_ff;
            best_idx_in = i_ff[IW-1:0];
            best_val_in = outer_ff;
         end
         if (eq_cnt_ff == CW'(1)) begin
            rsp_in.kind           = mufind_pkg::KIND_UNIQUE;
            rsp_in.position       = mufind_pkg::POS_W'(i_ff);
            rsp_in.reported_value = outer_ff;
            rsp_in.occurrences    = mufind_pkg::OCC_W'(1);
            rsp_in.overflow       = ovf_ff;
            rsp_in.last_result    = 1'b0;
            rsp_valid_in          = 1'b1;
         end
         i_in = i_ff + CW'(1);
      end

      if (cmd.mode) begin
         rsp_in.kind           = mufind_pkg::KIND_MODE;
         rsp_in.position       = mufind_pkg::POS_W'(best_idx_ff);
         rsp_in.reported_value = best_val_ff;
         rsp_in.occurrences    = mufind_pkg::OCC_W'(best_cnt_ff);
         rsp_in.overflow       = ovf_ff;
         rsp_in.last_result    = 1'b1;
         rsp_valid_in          = 1'b1;
         cnt_in                = '0;
         ovf_in                = 1'b0;
         i_in                  = '0;
         best_cnt_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         eq_cnt_ff    <= '0;
         best_cnt_ff  <= '0;
         lat_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         eq_cnt_ff    <= eq_cnt_in;
         best_cnt_ff  <= best_cnt_in;
         lat_ff       <= cmd.fetch;
         cmp_vld_ff   <= cmd.sweep;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff    <= outer_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/mode_and_unique_finder_top.sv]
// mode_and_unique_finder_top: finds unique values and the mode of a loaded set
// request channel: one signed value per request, last_item closes the set and starts the
// search. values beyond MAX_ITEMS are dropped and flagged as overflow on every report
// response channel: one unique report per value seen exactly once, in index order, then
// a mode report (last_result set) with the most frequent value, lowest index on ties
// timing: loading takes one cycle per request. after the last request each stored value
// gets one read of the value, a sweep that reads every stored value from the
// single-read-port store through the equality counter, a drain state and a decision
// state, and the mode report follows the decision on the last value
// requests are taken only while loading; during the search req_ready stays low
// the response register frees the datapath: the next set may load while the mode report
// waits. a stalled receiver holds the search at the next report until the slot frees
// reset clears the fill count, overflow flag and response valid; the store itself is
// not cleared, and only entries written in the current set are ever read
// uses mufind_pkg, mufind_ctrl, mufind_dp
module mode_and_unique_finder_top #(
   parameter int unsigned MAX_ITEMS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mufind_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mufind_pkg::rsp_type rsp_data
);

   mufind_pkg::cmd_type    cmd;
   mufind_pkg::status_type status;

   mufind_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_item),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mufind_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/report_checker.sv]
// report_checker: watches both channels of the mode and unique finder, predicts
// the unique and mode reports of every closed set and compares them in order
// depends on mufind_pkg
`timescale 1ns / 1ps

module report_checker #(
   parameter int unsigned MAX_ITEMS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  mufind_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  mufind_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending
);

   logic signed [mufind_pkg::VALUE_W-1:0] set_values [MAX_ITEMS];
   int unsigned                           set_size = 0;
   logic                                  set_dropped = 1'b0;
   mufind_pkg::rsp_type                   expected_reports [$];
   int                                    mismatches = 0;

   function automatic string format_report(mufind_pkg::rsp_type r);
      return $sformatf("kind %0d pos %0d value %0d occ %0d ovf %0d last %0d",
                       r.kind, r.position, r.reported_value, r.occurrences,
                       r.overflow, r.last_result);
   endfunction

   function automatic mufind_pkg::rsp_type make_report(logic kind, int unsigned idx,
                                                       int unsigned occ, logic last);
      mufind_pkg::rsp_type r;
      r.kind           = kind;
      r.position       = mufind_pkg::POS_W'(idx);
      r.reported_value = set_values[idx];
      r.occurrences    = mufind_pkg::OCC_W'(occ);
      r.overflow       = set_dropped;
      r.last_result    = last;
      return r;
   endfunction

   function automatic int unsigned count_matches(int unsigned idx);
      int unsigned n;
      n = 0;
      for (int unsigned j = 0; j < set_size; j++) begin
         if (set_values[j] == set_values[idx]) n++;
      end
      return n;
   endfunction

   task automatic close_set();
      int unsigned hits;
      int unsigned best_idx;
      int unsigned best_hits;
      best_idx  = 0;
      best_hits = 0;
      for (int unsigned i = 0; i < set_size; i++) begin
         hits = count_matches(i);
         if (hits == 1) begin
            expected_reports.push_back(make_report(mufind_pkg::KIND_UNIQUE, i, 1, 1'b0));
         end
         // strict greater keeps the lowest index on a tie
         if (hits > best_hits) begin
            best_hits = hits;
            best_idx  = i;
         end
      end
      expected_reports.push_back(make_report(mufind_pkg::KIND_MODE, best_idx, best_hits,
                                             1'b1));
      set_size    = 0;
      set_dropped = 1'b0;
   endtask

   task automatic absorb_request(mufind_pkg::req_type r);
      // a full store drops the value, even one that closes the set
      if (set_size < MAX_ITEMS) begin
         set_values[set_size] = r.value;
         set_size++;
      end else begin
         set_dropped = 1'b1;
      end
      if (r.last_item) close_set();
   endtask

   task automatic check_report(mufind_pkg::rsp_type got);
      mufind_pkg::rsp_type want;
      if (expected_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected report: %s", format_report(got));
         return;
      end
      want = expected_reports.pop_front();
      if (got.kind !== want.kind || got.position !== want.position ||
          got.reported_value !== want.reported_value ||
          got.occurrences !== want.occurrences || got.overflow !== want.overflow ||
          got.last_result !== want.last_result) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("report mismatch at %0t", $realtime);
            $display("   wanted %s", format_report(want));
            $display("   got    %s", format_report(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_size    = 0;
         set_dropped = 1'b0;
         expected_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_report(rsp_data);
         if (req_valid && req_ready) absorb_request(req_data);
      end
      fail_count <= mismatches;
      pending    <= expected_reports.size();
   end

endmodule

[bench/testbench.sv]
// testbench: drives sets of values into mode_and_unique_finder_top in bursts with
// a stalling receiver and gives the verdict from report_checker
// depends on mufind_pkg, mode_and_unique_finder_top, report_checker
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned MAX_ITEMS     = 32;
   localparam int unsigned RANDOM_ITEMS  = 460;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 1200;
   localparam int          DIRECTED_N    = 21;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   mufind_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   mufind_pkg::rsp_type rsp_data;

   int          fail_count;
   int          pending;
   int unsigned burst_left = 0;
   int unsigned random_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   int unsigned stall_style = 0;

   mufind_pkg::req_type directed_items [DIRECTED_N] = '{
      {32'sh8000_0000, 1'b1},
      {32'sh7FFF_FFFF, 1'b0}, {32'sh7FFF_FFFF, 1'b1},
      {32'sh0000_0000, 1'b0}, {32'shFFFF_FFFF, 1'b0}, {32'sh0000_0000, 1'b0},
      {32'sh0000_0005, 1'b1},
      // tie between 3 and 7, lowest index wins
      {32'sh0000_0003, 1'b0}, {32'sh0000_0007, 1'b0}, {32'sh0000_0007, 1'b0},
      {32'sh0000_0003, 1'b0}, {32'sh0000_0009, 1'b1},
      {32'sh0000_0001, 1'b0}, {32'sh0000_0002, 1'b0}, {32'sh0000_0003, 1'b0},
      {32'sh0000_0004, 1'b1},
      // nothing unique here
      {-32'sd5, 1'b0}, {32'sh0000_0008, 1'b0}, {-32'sd5, 1'b0}, {-32'sd5, 1'b0},
      {32'sh0000_0008, 1'b1}
   };

   mode_and_unique_finder_top #(.MAX_ITEMS(MAX_ITEMS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   report_checker #(.MAX_ITEMS(MAX_ITEMS)) mode_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver switches between always ready, light stalls and heavy stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_left  <= $urandom_range(20, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   task automatic send_request(input logic signed [mufind_pkg::VALUE_W-1:0] v,
                               input logic last);
      mufind_pkg::req_type item;
      int                  gap;
      item.value     = v;
      item.last_item = last;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // values mostly come from a small palette so that repeats are common
   task automatic send_random_set(input int unsigned len);
      logic signed [mufind_pkg::VALUE_W-1:0] palette [6];
      logic signed [mufind_pkg::VALUE_W-1:0] v;
      int unsigned                           palette_n;
      palette_n = $urandom_range(1, 6);
      for (int i = 0; i < 6; i++) palette[i] = $urandom;
      for (int unsigned k = 0; k < len; k++) begin
         if ($urandom_range(0, 3) == 0) v = $urandom;
         else v = palette[$urandom_range(0, palette_n - 1)];
         send_request(v, k == len - 1);
      end
      random_sent += len;
   endtask

   initial begin
      int unsigned len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         send_request(directed_items[i].value, directed_items[i].last_item);
      end

      // exactly full store, then a set whose tail and closing request are dropped
      send_random_set(MAX_ITEMS);
      send_random_set(MAX_ITEMS + 2);
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0: len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            1, 2: len = $urandom_range(11, MAX_ITEMS);
            default: len = $urandom_range(1, 10);
         endcase
         send_random_set(len);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
